// ===== design/cfst_pkg.sv =====
// shared types, constants and helpers for the can frame to text encoder
`timescale 1ns / 1ps
`default_nettype none

package cfst_pkg;

	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned CHAR_W     = 7;
	localparam int unsigned ID_W       = 32;
	localparam int unsigned PAYLOAD_W  = 64;
	localparam int unsigned PADDR_W    = 3;

	localparam logic [3:0] MAX_LEN       = 4'd8;
	localparam logic [2:0] EXT_TOP_DIGIT = 3'd7;
	localparam logic [2:0] STD_TOP_DIGIT = 3'd2;

	localparam logic [CHAR_W-1:0] CH_EXT_LETTER = 7'h54;
	localparam logic [CHAR_W-1:0] CH_STD_LETTER = 7'h74;
	localparam logic [CHAR_W-1:0] CH_ZERO       = 7'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 7'h37;
	localparam logic [CHAR_W-1:0] CH_CR         = 7'h0D;

	localparam logic REG_CHANNEL_OPEN = 1'b0;

	typedef logic [2:0] step_t;

	localparam step_t STEP_WAIT    = 3'd0;
	localparam step_t STEP_LETTER  = 3'd1;
	localparam step_t STEP_ID      = 3'd2;
	localparam step_t STEP_LEN     = 3'd3;
	localparam step_t STEP_DATA_HI = 3'd4;
	localparam step_t STEP_DATA_LO = 3'd5;
	localparam step_t STEP_CR      = 3'd6;

	typedef enum logic [2:0] {
		SRC_LETTER  = 3'd0,
		SRC_ID_NIB  = 3'd1,
		SRC_LEN     = 3'd2,
		SRC_DATA_HI = 3'd3,
		SRC_DATA_LO = 3'd4,
		SRC_CR      = 3'd5
	} src_t;

	typedef enum logic [2:0] {
		COND_NEXT       = 3'd0,
		COND_GOTO       = 3'd1,
		COND_IDLE       = 3'd2,
		COND_DIG_MORE   = 3'd3,
		COND_NO_BYTES   = 3'd4,
		COND_MORE_BYTES = 3'd5
	} cond_t;

	typedef struct packed {
		logic  emit;
		src_t  src;
		logic  last;
		cond_t cond;
		step_t target;
		logic  load_dig;
		logic  dec_dig;
		logic  next_byte;
	} ucode_t;

	typedef struct packed {
		logic dig_zero;
		logic cnt_zero;
		logic cnt_one;
	} dp_status_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
		logic [CHAR_W-1:0] v7;
		v7 = {3'b000, v};
		return (v < 4'd10) ? (CH_ZERO + v7) : (CH_ALPHA_BASE + v7);
	endfunction

endpackage

`default_nettype wire

// ===== design/cfst_ucode_rom.sv =====
// microcode rom holding the text line program
`timescale 1ns / 1ps
`default_nettype none

module cfst_ucode_rom
	import cfst_pkg::*;
(
	input  wire step_t  step,
	output ucode_t      uword
);

	always_comb begin
		uword = '0;
		case (step)
			STEP_WAIT: begin
				uword.cond   = COND_IDLE;
				uword.target = STEP_WAIT;
			end
			STEP_LETTER: begin
				uword.emit     = 1'b1;
				uword.src      = SRC_LETTER;
				uword.cond     = COND_NEXT;
				uword.load_dig = 1'b1;
			end
			STEP_ID: begin
				uword.emit    = 1'b1;
				uword.src     = SRC_ID_NIB;
				uword.cond    = COND_DIG_MORE;
				uword.target  = STEP_ID;
				uword.dec_dig = 1'b1;
			end
			STEP_LEN: begin
				uword.emit   = 1'b1;
				uword.src    = SRC_LEN;
				uword.cond   = COND_NO_BYTES;
				uword.target = STEP_CR;
			end
			STEP_DATA_HI: begin
				uword.emit = 1'b1;
				uword.src  = SRC_DATA_HI;
				uword.cond = COND_NEXT;
			end
			STEP_DATA_LO: begin
				uword.emit      = 1'b1;
				uword.src       = SRC_DATA_LO;
				uword.cond      = COND_MORE_BYTES;
				uword.target    = STEP_DATA_HI;
				uword.next_byte = 1'b1;
			end
			STEP_CR: begin
				uword.emit   = 1'b1;
				uword.src    = SRC_CR;
				uword.last   = 1'b1;
				uword.cond   = COND_GOTO;
				uword.target = STEP_WAIT;
			end
			default: begin
				uword.cond   = COND_GOTO;
				uword.target = STEP_WAIT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/cfst_datapath.sv =====
// frame registers, digit and byte counters and character select
`timescale 1ns / 1ps
`default_nettype none

module cfst_datapath
	import cfst_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  wire [IN_DATA_W-1:0]   frame,
	input  wire                   step_en,
	input  wire ucode_t           uword,
	output dp_status_t            status,
	output logic [CHAR_W-1:0]     char_value
);

	logic [7:0] id_high, id_low, ext_id_mid, ext_id_low, length_byte;
	logic [PAYLOAD_W-1:0] payload;

	logic                  ext_q;
	logic [ID_W-1:0]       id_q;
	logic [3:0]            len_q;
	logic [3:0]            cnt_q;
	logic [2:0]            dig_q;
	logic [PAYLOAD_W-1:0]  data_q;
	logic [3:0]            len_clamped;

	assign id_high     = frame[7:0];
	assign id_low      = frame[15:8];
	assign ext_id_mid  = frame[23:16];
	assign ext_id_low  = frame[31:24];
	assign length_byte = frame[39:32];
	assign payload     = frame[103:40];

	assign len_clamped = (length_byte[3:0] > MAX_LEN) ? MAX_LEN : length_byte[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q <= '0;
			cnt_q <= '0;
		end else begin
			if (load) begin
				cnt_q <= len_clamped;
			end else if (step_en && uword.next_byte) begin
				cnt_q <= cnt_q - 4'd1;
			end
			if (step_en && uword.load_dig) begin
				dig_q <= ext_q ? EXT_TOP_DIGIT : STD_TOP_DIGIT;
			end else if (step_en && uword.dec_dig) begin
				dig_q <= dig_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ext_q <= id_low[3];
			if (id_low[3]) begin
				id_q <= {3'b000, id_high, id_low[7:5], id_low[1:0], ext_id_mid, ext_id_low};
			end else begin
				id_q <= {21'd0, id_high, id_low[7:5]};
			end
			len_q  <= len_clamped;
			data_q <= payload;
		end else if (step_en && uword.next_byte) begin
			data_q <= {8'd0, data_q[PAYLOAD_W-1:8]};
		end
	end

	assign status.dig_zero = (dig_q == 3'd0);
	assign status.cnt_zero = (cnt_q == 4'd0);
	assign status.cnt_one  = (cnt_q == 4'd1);

	always_comb begin
		case (uword.src)
			SRC_LETTER:  char_value = ext_q ? CH_EXT_LETTER : CH_STD_LETTER;
			SRC_ID_NIB:  char_value = hex_char(id_q[{dig_q, 2'b00} +: 4]);
			SRC_LEN:     char_value = CH_ZERO + {3'b000, len_q};
			SRC_DATA_HI: char_value = hex_char(data_q[7:4]);
			SRC_DATA_LO: char_value = hex_char(data_q[3:0]);
			SRC_CR:      char_value = CH_CR;
			default:     char_value = CH_CR;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/cfst_sequencer.sv =====
// step counter with conditional jumps over the microcode rom
`timescale 1ns / 1ps
`default_nettype none

module cfst_sequencer
	import cfst_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_fire,
	input  wire         channel_open,
	input  wire         slot_free,
	input  wire dp_status_t status,
	output ucode_t      uword,
	output logic        idle,
	output logic        step_en
);

	step_t step_q;
	logic  take;

	cfst_ucode_rom u_rom (
		.step  (step_q),
		.uword (uword)
	);

	assign idle    = (step_q == STEP_WAIT);
	assign step_en = !uword.emit || slot_free;

	always_comb begin
		case (uword.cond)
			COND_NEXT:       take = 1'b0;
			COND_GOTO:       take = 1'b1;
			COND_IDLE:       take = !(in_fire && channel_open);
			COND_DIG_MORE:   take = !status.dig_zero;
			COND_NO_BYTES:   take = status.cnt_zero;
			COND_MORE_BYTES: take = !status.cnt_one;
			default:         take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (step_en) begin
			step_q <= take ? uword.target : step_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

// ===== design/can_frame_to_slcan_text.sv =====
// top level: can frame to ascii text line encoder
`timescale 1ns / 1ps
`default_nettype none

// Takes one received CAN frame per word and sends it as an ASCII text line, one
// character per output word: 't' plus 3 id digits for a standard frame or 'T' plus
// 8 id digits for an extended one, the length digit (clamped to 8), two uppercase
// hex digits per data byte and a carriage return flagged with tlast. The microcode
// sequencer issues one character per step and takes the frame in one more step.
// With channel_open cleared frames are taken and dropped without output.
module can_frame_to_slcan_text
	import cfst_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,

	input  wire                     s_axis_tvalid,
	output logic                    s_axis_tready,
	// id_high, id_low, ext_id_mid, ext_id_low, length_byte, payload
	input  wire [IN_DATA_W-1:0]     s_axis_tdata,

	output logic                    m_axis_tvalid,
	input  wire                     m_axis_tready,
	// char_out, zero pad
	output logic [OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                    m_axis_tlast,

	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire [PADDR_W-1:0]       paddr,
	input  wire [31:0]              pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic              open_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic              idle;
	logic              step_en;
	logic              in_fire;
	logic              slot_free;
	logic              emit_fire;
	ucode_t            uword;
	dp_status_t        status;
	logic [CHAR_W-1:0] char_value;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHANNEL_OPEN) ? {31'd0, open_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_CHANNEL_OPEN)) begin
			open_q <= pwdata[0];
		end
	end

	assign s_axis_tready = idle;
	assign in_fire       = s_axis_tvalid && idle;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign emit_fire     = uword.emit && step_en;

	cfst_sequencer u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.channel_open (open_q),
		.slot_free    (slot_free),
		.status       (status),
		.uword        (uword),
		.idle         (idle),
		.step_en      (step_en)
	);

	cfst_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_fire),
		.frame      (s_axis_tdata),
		.step_en    (step_en),
		.uword      (uword),
		.status     (status),
		.char_value (char_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_char_q <= char_value;
			out_last_q <= uword.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_char_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
